FILE: hdl/dstq_pkg.sv
// dstq_pkg: shared types and codes for the deadline sorted timer queue.
// No dependencies.
`default_nettype none
package dstq_pkg;
  localparam logic [1:0] KIND_SCHED   = 2'd0;
  localparam logic [1:0] KIND_CANCEL  = 2'd1;
  localparam logic [1:0] KIND_RESCHED = 2'd2;
  localparam logic [1:0] KIND_TICK    = 2'd3;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_FULL     = 2'd1;
  localparam logic [1:0] ST_NOTFOUND = 2'd2;

  typedef struct packed {
    logic [63:0] deadline;
    logic [63:0] period;
    logic [31:0] id;
    logic [7:0]  target;
  } entry_t;

  // row operation broadcast to every cell
  typedef enum logic [1:0] {
    OP_HOLD,
    OP_INSERT,
    OP_REMOVE
  } cell_op_t;

  typedef struct packed {
    cell_op_t    op;
    entry_t      ent;
  } cell_ctl_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_FIND,
    S_REMOVE,
    S_INSERT,
    S_TICK,
    S_OUT
  } state_t;
endpackage
`default_nettype wire

FILE: hdl/dstq_cell.sv
// dstq_cell: one slot of the sorted row. Holds an entry and a valid flag,
// takes its left or right neighbor on shifts. Depends on dstq_pkg.
`default_nettype none
module dstq_cell (
  input  wire                 clk,
  input  wire                 rst_n,
  input  dstq_pkg::cell_ctl_t ctl,
  input  wire                 sel,          // this cell is the op position
  input  wire                 shift,        // this cell is past the position
  input  dstq_pkg::entry_t    left_ent,
  input  wire                 left_vld,
  input  dstq_pkg::entry_t    right_ent,
  input  wire                 right_vld,
  output dstq_pkg::entry_t    ent,
  output logic                vld
);
  dstq_pkg::entry_t ent_r, ent_nxt;
  logic vld_r, vld_nxt;

  always_comb begin
    ent_nxt = ent_r;
    vld_nxt = vld_r;
    unique case (ctl.op)
      dstq_pkg::OP_INSERT: begin
        if (sel) begin
          ent_nxt = ctl.ent;
          vld_nxt = 1'b1;
        end else if (shift) begin
          ent_nxt = left_ent;
          vld_nxt = left_vld;
        end
      end
      dstq_pkg::OP_REMOVE: begin
        if (sel || shift) begin
          ent_nxt = right_ent;
          vld_nxt = right_vld;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    ent_r <= ent_nxt;
    if (!rst_n) vld_r <= 1'b0;
    else vld_r <= vld_nxt;
  end

  assign ent = ent_r;
  assign vld = vld_r;
endmodule
`default_nettype wire

FILE: hdl/deadline_sorted_timer_queue.sv
// Top level of the deadline sorted timer queue: control sequencer and row of
// dstq_cell slots. Depends on dstq_pkg and dstq_cell.
//
// Entries sit in a row of DEPTH cells kept in deadline order with valid
// flags. Every cell compares against a broadcast key in parallel, and the row
// shifts by one as a whole. One item is in work at a time, and in_tready is
// high only while idle. A schedule steps through accept, insert and output
// load. A cancel steps through accept, search, remove and output load, or
// accept, search and output load when the handle is not found. A reschedule
// adds one insert after the remove, or ends like a cancel when the handle is
// not found. A tick takes the accept step and one front check per firing,
// plus one reinsert step per periodic entry that fires, plus a final check
// that sends the last beat; an idle tick has only the accept step and the
// final check. Each firing beat is held back until the next check so that
// its last flag is known. A tick sends at most MAX_FIRE beats. A stalled
// output register holds the sequencer at its output step.
`default_nettype none
module deadline_sorted_timer_queue #(
  parameter int DEPTH    = 16,
  parameter int MAX_FIRE = 64
) (
  input  wire         clk,
  input  wire         rst_n,
  input  wire         in_tvalid,
  output logic        in_tready,
  // kind[1:0], now_time[65:2], delay_us[129:66], repeat_enable[130],
  // target_id[138:131], entry_handle[170:139]
  input  wire [175:0] in_tdata,
  output logic        out_tvalid,
  input  wire         out_tready,
  // status[1:0], new_handle[33:2], fired[34], fired_target[42:35]
  output logic [47:0] out_tdata,
  output logic        out_tlast
);
  localparam int PW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam int FW = $clog2(MAX_FIRE + 1);

  dstq_pkg::state_t st_r, st_nxt;
  logic [1:0]  kind_r;
  logic [63:0] now_r;
  logic [31:0] hdl_r;
  logic [CW-1:0] cnt_r;
  logic [31:0] hcnt_r;
  logic [FW-1:0] nfire_r;
  logic [PW-1:0] pos_r;
  dstq_pkg::entry_t pend_r;   // entry waiting to be reinserted
  logic        pend_vld_r;
  logic [1:0]  req_st_r;      // status of the item in work
  logic [31:0] req_h_r;
  logic        hb_vld_r;      // firing beat held until its last flag is known
  logic [7:0]  hb_tgt_r;

  logic [1:0]  ost_r;
  logic [31:0] oh_r;
  logic        of_r, ol_r, ov_r;
  logic [7:0]  ot_r;

  dstq_pkg::entry_t cent [DEPTH];
  logic [DEPTH-1:0] cvld;
  dstq_pkg::cell_ctl_t ctl;
  logic [DEPTH-1:0] sel, shf, lt, hit;

  // parallel compares across the row
  always_comb begin
    for (int i = 0; i < DEPTH; i++) begin
      lt[i]  = cvld[i] && (cent[i].deadline < ctl.ent.deadline);
      hit[i] = cvld[i] && (cent[i].id == hdl_r) && (hdl_r != 32'd0);
    end
  end

  // first position where lt is false; lt is a prefix in a sorted row
  logic [DEPTH-1:0] ins_sel;
  logic [DEPTH-1:0] hit_first;
  always_comb begin
    for (int i = 0; i < DEPTH; i++) begin
      ins_sel[i]   = !lt[i] && (i == 0 || lt[(i == 0) ? 0 : i-1]);
      hit_first[i] = hit[i] && ((hit & ((DEPTH'(1) << i) - DEPTH'(1))) == '0);
    end
  end

  logic [PW-1:0] hit_pos;
  always_comb begin
    hit_pos = '0;
    for (int i = 0; i < DEPTH; i++)
      if (hit_first[i]) hit_pos = PW'(i);
  end

  logic [63:0] diff;
  logic        due;
  logic        more;
  assign diff = cent[0].deadline - now_r;
  assign due  = cvld[0] && (diff == 64'd0 || diff[63]);
  assign more = due && (nfire_r != FW'(MAX_FIRE));

  logic out_free;
  assign out_free = !ov_r || out_tready;
  assign in_tready = (st_r == dstq_pkg::S_IDLE);

  logic full;
  assign full = (cnt_r == CW'(DEPTH));
  logic sched_ok;
  assign sched_ok = (in_tdata[1:0] == dstq_pkg::KIND_SCHED) && !full;
  logic [31:0] new_hdl;
  assign new_hdl = (hcnt_r == 32'd0) ? 32'd1 : hcnt_r;

  logic fire;
  assign fire = (st_r == dstq_pkg::S_TICK) && !pend_vld_r && more &&
                (!hb_vld_r || out_free);
  logic out_load;
  assign out_load = ((st_r == dstq_pkg::S_OUT) && out_free) ||
                    ((st_r == dstq_pkg::S_TICK) && !pend_vld_r &&
                     ((fire && hb_vld_r) || (!more && out_free)));

  // next state
  always_comb begin
    st_nxt = st_r;
    unique case (st_r)
      dstq_pkg::S_IDLE:
        if (in_tvalid) begin
          if (in_tdata[1:0] == dstq_pkg::KIND_TICK) st_nxt = dstq_pkg::S_TICK;
          else if (in_tdata[1:0] == dstq_pkg::KIND_SCHED) st_nxt = dstq_pkg::S_INSERT;
          else st_nxt = dstq_pkg::S_FIND;
        end
      dstq_pkg::S_FIND:
        st_nxt = (hit != '0) ? dstq_pkg::S_REMOVE : dstq_pkg::S_OUT;
      dstq_pkg::S_REMOVE:
        st_nxt = (kind_r == dstq_pkg::KIND_RESCHED) ? dstq_pkg::S_INSERT : dstq_pkg::S_OUT;
      dstq_pkg::S_INSERT:
        st_nxt = dstq_pkg::S_OUT;
      dstq_pkg::S_TICK:
        if (!pend_vld_r && !more && out_free) st_nxt = dstq_pkg::S_IDLE;
      dstq_pkg::S_OUT:
        if (out_free) st_nxt = dstq_pkg::S_IDLE;
      default: st_nxt = dstq_pkg::S_IDLE;
    endcase
  end

  // row control
  always_comb begin
    ctl.op  = dstq_pkg::OP_HOLD;
    ctl.ent = pend_r;
    sel = '0;
    shf = '0;
    if (st_r == dstq_pkg::S_INSERT && !(kind_r == dstq_pkg::KIND_SCHED && full)) begin
      ctl.op = dstq_pkg::OP_INSERT;
      sel = ins_sel;
      for (int i = 1; i < DEPTH; i++) shf[i] = sel[i-1] | shf[i-1];
    end else if (st_r == dstq_pkg::S_TICK && pend_vld_r) begin
      ctl.op = dstq_pkg::OP_INSERT;
      sel = ins_sel;
      for (int i = 1; i < DEPTH; i++) shf[i] = sel[i-1] | shf[i-1];
    end else if (st_r == dstq_pkg::S_REMOVE) begin
      ctl.op = dstq_pkg::OP_REMOVE;
      sel = DEPTH'(1) << pos_r;
      for (int i = 1; i < DEPTH; i++) shf[i] = sel[i-1] | shf[i-1];
    end else if (fire) begin
      ctl.op = dstq_pkg::OP_REMOVE;
      sel = DEPTH'(1);
      for (int i = 1; i < DEPTH; i++) shf[i] = 1'b1;
    end
  end

  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    dstq_pkg::entry_t le, re;
    logic lv, rv;
    if (g == 0) begin : g_l0
      assign le = pend_r;
      assign lv = 1'b0;
    end else begin : g_l
      assign le = cent[g-1];
      assign lv = cvld[g-1];
    end
    if (g == DEPTH - 1) begin : g_rn
      assign re = pend_r;
      assign rv = 1'b0;
    end else begin : g_r
      assign re = cent[g+1];
      assign rv = cvld[g+1];
    end
    dstq_cell u_cell (
      .clk(clk), .rst_n(rst_n), .ctl(ctl), .sel(sel[g]), .shift(shf[g]),
      .left_ent(le), .left_vld(lv), .right_ent(re), .right_vld(rv),
      .ent(cent[g]), .vld(cvld[g])
    );
  end

  // datapath and output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= dstq_pkg::S_IDLE;
      cnt_r <= '0;
      hcnt_r <= '0;
      ov_r <= 1'b0;
      pend_vld_r <= 1'b0;
      hb_vld_r <= 1'b0;
      nfire_r <= '0;
    end else begin
      st_r <= st_nxt;
      if (out_load) ov_r <= 1'b1;
      else if (out_tready) ov_r <= 1'b0;
      unique case (st_r)
        dstq_pkg::S_IDLE:
          if (in_tvalid) begin
            kind_r  <= in_tdata[1:0];
            now_r   <= in_tdata[65:2];
            hdl_r   <= in_tdata[170:139];
            nfire_r <= '0;
            req_st_r <= (in_tdata[1:0] == dstq_pkg::KIND_SCHED && full) ?
                        dstq_pkg::ST_FULL : dstq_pkg::ST_OK;
            req_h_r  <= sched_ok ? new_hdl : 32'd0;
            pend_r.deadline <= in_tdata[65:2] + in_tdata[129:66];
            pend_r.period   <= in_tdata[130] ? in_tdata[129:66] : 64'd0;
            pend_r.target   <= in_tdata[138:131];
            pend_r.id       <= sched_ok ? new_hdl : 32'd0;
            if (sched_ok) hcnt_r <= new_hdl + 32'd1;
          end
        dstq_pkg::S_FIND: begin
          pos_r <= hit_pos;
          if (hit == '0) req_st_r <= dstq_pkg::ST_NOTFOUND;
          pend_r.period <= cent[hit_pos].period;
          pend_r.target <= cent[hit_pos].target;
          pend_r.id     <= hdl_r;
        end
        dstq_pkg::S_REMOVE: cnt_r <= cnt_r - CW'(1);
        dstq_pkg::S_INSERT:
          if (ctl.op == dstq_pkg::OP_INSERT) cnt_r <= cnt_r + CW'(1);
        dstq_pkg::S_TICK: begin
          if (pend_vld_r) begin
            pend_vld_r <= 1'b0;
            cnt_r <= cnt_r + CW'(1);
          end else if (fire) begin
            if (hb_vld_r) begin
              ost_r <= dstq_pkg::ST_OK;
              oh_r <= '0;
              of_r <= 1'b1;
              ot_r <= hb_tgt_r;
              ol_r <= 1'b0;
            end
            hb_vld_r <= 1'b1;
            hb_tgt_r <= cent[0].target;
            cnt_r <= cnt_r - CW'(1);
            nfire_r <= nfire_r + FW'(1);
            pend_r.deadline <= cent[0].deadline + cent[0].period;
            pend_r.period   <= cent[0].period;
            pend_r.id       <= cent[0].id;
            pend_r.target   <= cent[0].target;
            pend_vld_r <= (cent[0].period != 64'd0);
          end else if (!more && out_free) begin
            // closing beat: the held firing, or an idle beat
            ost_r <= dstq_pkg::ST_OK;
            oh_r <= '0;
            of_r <= hb_vld_r;
            ot_r <= hb_vld_r ? hb_tgt_r : 8'd0;
            ol_r <= 1'b1;
            hb_vld_r <= 1'b0;
          end
        end
        dstq_pkg::S_OUT:
          if (out_free) begin
            ost_r <= req_st_r;
            oh_r <= req_h_r;
            of_r <= 1'b0;
            ot_r <= '0;
            ol_r <= 1'b1;
          end
        default: ;
      endcase
    end
  end

  assign out_tvalid = ov_r;
  assign out_tlast  = ol_r;
  assign out_tdata  = {5'd0, ot_r, of_r, oh_r, ost_r};
endmodule
`default_nettype wire

FILE: hdl/dstq_checker.sv
// dstq_checker: port-level assertions for deadline_sorted_timer_queue,
// bound to the top level. Depends on the top level's ports only.
`default_nettype none
module dstq_checker (
  input wire         clk,
  input wire         rst_n,
  input wire         in_tvalid,
  input wire         in_tready,
  input wire         out_tvalid,
  input wire         out_tready,
  input wire [47:0]  out_tdata,
  input wire         out_tlast
);
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("output beat dropped while stalled");
  a_nonfire_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tdata[34] |-> out_tlast)
    else $error("non-firing beat without last");
  a_handle_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[33:2] != 32'd0 |-> out_tdata[1:0] == 2'd0)
    else $error("handle with error status");
  a_fire_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[34] |-> out_tdata[33:0] == 34'd0)
    else $error("firing beat carries status or handle");
  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("input beat accepted while busy");
endmodule

bind deadline_sorted_timer_queue dstq_checker u_dstq_checker (
  .clk(clk), .rst_n(rst_n), .in_tvalid(in_tvalid), .in_tready(in_tready),
  .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
  .out_tlast(out_tlast)
);
`default_nettype wire

FILE: tb/tb_deadline_sorted_timer_queue.sv
// Testbench for deadline_sorted_timer_queue: drives schedule, cancel, reschedule and tick
// beats and checks every result beat against a behavioral model of the sorted timer table.
// Depends on dstq_pkg and the block's RTL.
`timescale 1ns / 1ps
`default_nettype none

typedef struct packed {
  logic [1:0]  status;
  logic [31:0] new_handle;
  logic        fired;
  logic [7:0]  fired_target;
  logic        last;
} timer_result_t;

class timer_scoreboard;
  localparam int NSLOT = 16;
  localparam int FIRE_CAP = 64;
  logic [63:0] slot_deadline[NSLOT];
  logic [63:0] slot_period[NSLOT];
  logic [31:0] slot_handle[NSLOT];
  logic [7:0]  slot_target[NSLOT];
  int          used;
  logic [31:0] next_handle;
  timer_result_t pending[$];
  int errors;
  int beats_checked;
  int firings;

  function new();
    used = 0;
    next_handle = 0;
    errors = 0;
    beats_checked = 0;
    firings = 0;
  endfunction

  function void put_sorted(logic [63:0] dl, logic [63:0] per, logic [31:0] h,
                           logic [7:0] tg);
    int pos;
    pos = 0;
    while (pos < used && slot_deadline[pos] < dl) pos++;
    for (int i = used; i > pos; i--) begin
      slot_deadline[i] = slot_deadline[i-1];
      slot_period[i] = slot_period[i-1];
      slot_handle[i] = slot_handle[i-1];
      slot_target[i] = slot_target[i-1];
    end
    slot_deadline[pos] = dl;
    slot_period[pos] = per;
    slot_handle[pos] = h;
    slot_target[pos] = tg;
    used++;
  endfunction

  function void drop_slot(int pos);
    for (int i = pos; i + 1 < used; i++) begin
      slot_deadline[i] = slot_deadline[i+1];
      slot_period[i] = slot_period[i+1];
      slot_handle[i] = slot_handle[i+1];
      slot_target[i] = slot_target[i+1];
    end
    used--;
  endfunction

  function void push(logic [1:0] st, logic [31:0] h, logic f, logic [7:0] tg, logic l);
    timer_result_t r;
    r.status = st;
    r.new_handle = h;
    r.fired = f;
    r.fired_target = tg;
    r.last = l;
    pending.push_back(r);
  endfunction

  function void note_request(logic [1:0] kind, logic [63:0] now, logic [63:0] dly,
                             logic rep, logic [7:0] tg, logic [31:0] h);
    int pos;
    int n;
    logic [63:0] diff, per, dl;
    logic [31:0] id;
    logic [7:0] t;
    if (kind == dstq_pkg::KIND_SCHED) begin
      if (used >= NSLOT) begin
        push(dstq_pkg::ST_FULL, '0, 1'b0, '0, 1'b1);
      end else begin
        if (next_handle == 0) next_handle = 32'd1;
        id = next_handle;
        next_handle = next_handle + 32'd1;
        put_sorted(now + dly, rep ? dly : 64'd0, id, tg);
        push(dstq_pkg::ST_OK, id, 1'b0, '0, 1'b1);
      end
    end else if (kind == dstq_pkg::KIND_CANCEL || kind == dstq_pkg::KIND_RESCHED) begin
      pos = used;
      for (int i = used - 1; i >= 0; i--)
        if (slot_handle[i] == h && h != 0) pos = i;
      if (pos >= used) begin
        push(dstq_pkg::ST_NOTFOUND, '0, 1'b0, '0, 1'b1);
      end else begin
        per = slot_period[pos];
        t = slot_target[pos];
        drop_slot(pos);
        if (kind == dstq_pkg::KIND_RESCHED) put_sorted(now + dly, per, h, t);
        push(dstq_pkg::ST_OK, '0, 1'b0, '0, 1'b1);
      end
    end else begin
      n = 0;
      while (used > 0 && n < FIRE_CAP) begin
        diff = slot_deadline[0] - now;
        if (diff != 0 && !diff[63]) break;
        dl = slot_deadline[0];
        per = slot_period[0];
        id = slot_handle[0];
        t = slot_target[0];
        drop_slot(0);
        push(dstq_pkg::ST_OK, '0, 1'b1, t, 1'b0);
        n++;
        if (per != 0) put_sorted(dl + per, per, id, t);
      end
      firings += n;
      if (n == 0) push(dstq_pkg::ST_OK, '0, 1'b0, '0, 1'b1);
      else pending[$].last = 1'b1;
    end
  endfunction

  function void check_beat(timer_result_t got);
    timer_result_t exp_r;
    beats_checked++;
    if (pending.size() == 0) begin
      errors++;
      if (errors <= 10) $display("ERROR: unexpected result beat %p", got);
      return;
    end
    exp_r = pending.pop_front();
    if (got !== exp_r) begin
      errors++;
      if (errors <= 10) $display("ERROR: result mismatch exp %p got %p", exp_r, got);
    end
  endfunction
endclass

module tb_deadline_sorted_timer_queue;
  localparam int WATCHDOG_CYCLES = 20000;

  logic         clk = 0;
  logic         rst_n = 0;
  logic         in_tvalid = 0;
  wire          in_tready;
  logic [175:0] in_tdata = '0;
  wire          out_tvalid;
  logic         out_tready = 0;
  wire  [47:0]  out_tdata;
  wire          out_tlast;

  timer_scoreboard sb;
  int  idle_pct = 23;
  int  stall_cycles = 0;
  bit  timed_out = 0;
  logic [63:0] now_us = 0;
  logic [31:0] recent_handle[$];

  deadline_sorted_timer_queue u_top (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tlast(out_tlast)
  );

  always #10 clk = ~clk;

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      timer_result_t r;
      r.status = out_tdata[1:0];
      r.new_handle = out_tdata[33:2];
      r.fired = out_tdata[34];
      r.fired_target = out_tdata[42:35];
      r.last = out_tlast;
      sb.check_beat(r);
      if (r.new_handle != 0) recent_handle.push_back(r.new_handle);
      if (recent_handle.size() > 24) void'(recent_handle.pop_front());
    end
  end

  always @(posedge clk) begin
    if (rst_n) out_tready <= ($urandom_range(99) >= idle_pct);
  end

  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) stall_cycles <= 0;
    else stall_cycles <= stall_cycles + 1;
    if (stall_cycles > WATCHDOG_CYCLES) begin
      timed_out = 1;
      $display("watchdog expired");
      $display("Simulation FAILED");
      $finish;
    end
  end

  task automatic send(logic [1:0] kind, logic [63:0] now, logic [63:0] dly, logic rep,
                      logic [7:0] tg, logic [31:0] h);
    while ($urandom_range(99) < idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tdata <= {5'd0, h, tg, rep, dly, now, kind};
    in_tvalid <= 1'b1;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    sb.note_request(kind, now, dly, rep, tg, h);
  endtask

  function automatic logic [31:0] pick_handle();
    if (recent_handle.size() == 0 || $urandom_range(9) == 0) return $urandom;
    return recent_handle[$urandom_range(recent_handle.size() - 1)];
  endfunction

  task automatic random_item();
    int sel;
    logic [63:0] dly;
    sel = $urandom_range(99);
    now_us = now_us + 64'($urandom_range(40));
    dly = ($urandom_range(19) == 0) ? {$urandom, $urandom} : 64'($urandom_range(120));
    if (sel < 35)
      send(dstq_pkg::KIND_SCHED, now_us, dly, 1'($urandom_range(1)), 8'($urandom), '0);
    else if (sel < 50)
      send(dstq_pkg::KIND_CANCEL, now_us, '0, 1'b0, '0, pick_handle());
    else if (sel < 62)
      send(dstq_pkg::KIND_RESCHED, now_us, dly, 1'b0, '0, pick_handle());
    else
      send(dstq_pkg::KIND_TICK, now_us, '0, 1'b0, '0, '0);
  endtask

  initial begin
    sb = new();
    repeat (9) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    // directed: empty tick, unknown handle, field extremes, table full, wrap
    send(dstq_pkg::KIND_TICK, '0, '0, 1'b0, '0, '0);
    send(dstq_pkg::KIND_CANCEL, '0, '0, 1'b0, '0, '0);
    send(dstq_pkg::KIND_RESCHED, '0, 64'd5, 1'b0, '0, 32'hFFFF_FFFF);
    send(dstq_pkg::KIND_SCHED, 64'hFFFF_FFFF_FFFF_FFF0, 64'h20, 1'b1, 8'hFF, 32'hFFFF_FFFF);
    send(dstq_pkg::KIND_SCHED, 64'd100, '0, 1'b1, 8'h01, '0);
    send(dstq_pkg::KIND_SCHED, 64'd100, 64'hFFFF_FFFF_FFFF_FFFF, 1'b0, 8'h80, '0);
    for (int i = 0; i < 14; i++)
      send(dstq_pkg::KIND_SCHED, 64'd100, 64'(i * 3), 1'(i % 2), 8'(i), '0);
    send(dstq_pkg::KIND_SCHED, 64'd100, 64'd1, 1'b0, 8'h55, '0);
    send(dstq_pkg::KIND_RESCHED, 64'd100, 64'd7, 1'b0, '0, 32'd3);
    send(dstq_pkg::KIND_CANCEL, 64'd100, '0, 1'b0, '0, 32'd4);
    send(dstq_pkg::KIND_TICK, 64'h0000_0000_0000_0200, '0, 1'b0, '0, '0);
    send(dstq_pkg::KIND_TICK, 64'hFFFF_FFFF_FFFF_FFFF, '0, 1'b0, '0, '0);
    send(dstq_pkg::KIND_TICK, 64'h7FFF_FFFF_FFFF_FFFF, '0, 1'b0, '0, '0);

    // clear the table
    for (int h = 1; h < 20; h++)
      send(dstq_pkg::KIND_CANCEL, '0, '0, 1'b0, '0, 32'(h));
    now_us = 64'd1000;

    idle_pct = 0;
    for (int i = 0; i < 30; i++) random_item();
    idle_pct = 23;
    for (int i = 0; i < 80; i++) random_item();
    in_tvalid <= 1'b0;

    while (sb.pending.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    $display("Checked %0d result beats, %0d timer firings.", sb.beats_checked, sb.firings);
    if (sb.errors == 0 && !timed_out) begin
      $display("Simulation PASSED");
    end else begin
      $display("%0d mismatches", sb.errors);
      $display("Simulation FAILED");
    end
    $finish;
  end
endmodule

`default_nettype wire
